FILE: rtl/cel_pkg.sv
// Shared types, codes and helpers for the coalescing event log.
package cel_pkg;

    localparam int LOG_DEPTH = 64;
    localparam int SLOT_W    = $clog2(LOG_DEPTH);
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        time_stamp;
        logic signed [15:0] temperature;
        logic [15:0]        humidity;
        logic [15:0]        distance;
        logic               button;
        logic [5:0]         read_index;
    } cmd_t;

    typedef struct packed {
        logic [6:0]         entry_count;
        logic               read_valid;
        logic [31:0]        read_time;
        logic signed [15:0] read_temperature;
        logic [15:0]        read_humidity;
        logic [15:0]        read_distance;
        logic               read_button;
        logic               coalesced;
        logic               dropped_oldest;
    } rsp_t;

    typedef struct packed {
        logic [31:0]        time_stamp;
        logic signed [15:0] temperature;
        logic [15:0]        humidity;
        logic [15:0]        distance;
        logic               button;
    } rec_t;

    // Map a log position (0 is oldest) to its physical slot.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] oldest,
                                                  input logic [CNT_W-1:0]  pos);
        return oldest + pos[SLOT_W-1:0];
    endfunction

endpackage

FILE: rtl/cel_chan_if.sv
// Valid/ready channel interfaces for the command and response streams.
interface cel_cmd_if
    import cel_pkg::*;
();
    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cel_rsp_if
    import cel_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/coalescing_event_log_unit.sv
// Coalescing event log: top level with record memory and command sequencer.
//
//   channel   dir   handshake      payload
//   cmd       in    valid/ready    cmd_t  (action, record, read_index)
//   rsp       out   valid/ready    rsp_t  (count, read entry, flags)
//   cfg       in    cfg_we only    coalesce_interval (31 bits)
//
// One command is in work at a time; cmd.ready is high only while idle.
// An append walks the log newest to oldest through the record memory, one
// entry per cycle, and stops at the first entry with the same button.
// The response sits in an output register; the next command is taken while it
// waits, but a finished command holds until that register is free.
// Reset clears count, oldest slot, interval and response valid; memory is not cleared.
module coalescing_event_log_unit
    import cel_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [30:0]   cfg_wdata,
    cel_cmd_if.sink       cmd,
    cel_rsp_if.source     rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic [30:0]       interval_reg;
    logic [SLOT_W-1:0] scan_pos_reg, scan_pos_next;
    cmd_t              cmd_reg, cmd_next;
    rsp_t              res_reg, res_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_data_reg, rsp_data_next;

    // record memory
    rec_t              mem [LOG_DEPTH];
    rec_t              mem_q;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    rec_t              wr_data;

    logic              accept;
    logic              out_free;
    logic [31:0]       scan_diff;
    logic [CNT_W-1:0]  cnt_w;
    logic [SLOT_W-1:0] old_w;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign scan_diff = cmd_reg.time_stamp - mem_q.time_stamp;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // write and read the record memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    // sequence each command
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        oldest_next    = oldest_reg;
        scan_pos_next  = scan_pos_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        cnt_w          = count_reg;
        old_w          = oldest_reg;

        // drop a taken response
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd.data;
                    res_next = '0;
                    unique case (cmd.data.action)
                        ACT_APPEND:
                        begin
                            if ((interval_reg != '0) && (count_reg != '0))
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = slot_of(oldest_reg, count_reg - 1'b1);
                                scan_pos_next = SLOT_W'(count_reg - 1'b1);
                                state_next    = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_WRITE;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next  = '0;
                            oldest_next = '0;
                            state_next  = S_DONE;
                        end
                        ACT_READ:
                        begin
                            if (CNT_W'(cmd.data.read_index) < count_reg)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = slot_of(oldest_reg, CNT_W'(cmd.data.read_index));
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // check the entry fetched last cycle, else fetch the next older one
                if (mem_q.button == cmd_reg.button)
                begin
                    if (scan_diff < {1'b0, interval_reg})
                    begin
                        count_next         = CNT_W'(scan_pos_reg);
                        res_next.coalesced = 1'b1;
                    end
                    state_next = S_WRITE;
                end
                else if (scan_pos_reg == '0)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_addr       = slot_of(oldest_reg, CNT_W'(scan_pos_reg - 1'b1));
                    scan_pos_next = scan_pos_reg - 1'b1;
                end
            end
            S_WRITE:
            begin
                // drop the oldest record when full, then store the new one
                if (count_reg >= CNT_W'(LOG_DEPTH))
                begin
                    old_w                   = oldest_reg + 1'b1;
                    cnt_w                   = count_reg - 1'b1;
                    res_next.dropped_oldest = 1'b1;
                end
                wr_en               = 1'b1;
                wr_addr             = slot_of(old_w, cnt_w);
                wr_data.time_stamp  = cmd_reg.time_stamp;
                wr_data.temperature = cmd_reg.temperature;
                wr_data.humidity    = cmd_reg.humidity;
                wr_data.distance    = cmd_reg.distance;
                wr_data.button      = cmd_reg.button;
                count_next          = cnt_w + 1'b1;
                oldest_next         = old_w;
                state_next          = S_DONE;
            end
            S_RDWAIT:
            begin
                res_next.read_valid       = 1'b1;
                res_next.read_time        = mem_q.time_stamp;
                res_next.read_temperature = mem_q.temperature;
                res_next.read_humidity    = mem_q.humidity;
                res_next.read_distance    = mem_q.distance;
                res_next.read_button      = mem_q.button;
                state_next                = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next             = res_reg;
                    rsp_data_next.entry_count = count_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            oldest_reg    <= '0;
            interval_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                interval_reg <= cfg_wdata;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        scan_pos_reg <= scan_pos_next;
        cmd_reg      <= cmd_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule
